FILE: rtl/bcpu_pkg.sv
package bcpu_pkg;

  // Opcode bytes
  localparam logic [7:0] OP_NOP   = 8'h00;
  localparam logic [7:0] OP_LDI   = 8'h10;
  localparam logic [7:0] OP_PRINT = 8'h20;
  localparam logic [7:0] OP_MOV   = 8'h30;
  localparam logic [7:0] OP_ADD   = 8'h40;
  localparam logic [7:0] OP_JZ    = 8'h50;
  localparam logic [7:0] OP_JMP   = 8'h51;
  localparam logic [7:0] OP_JNZ   = 8'h52;
  localparam logic [7:0] OP_LD    = 8'h60;
  localparam logic [7:0] OP_ST    = 8'h70;
  localparam logic [7:0] OP_PUSH  = 8'h80;
  localparam logic [7:0] OP_POP   = 8'h81;
  localparam logic [7:0] OP_HALT  = 8'hFF;

  // Config register indexes (paddr[2])
  localparam logic REG_START_ADDRESS = 1'b0;
  localparam logic REG_INITIAL_STACK = 1'b1;

  // Depth of the result queue
  localparam int OQ_DEPTH = 3;

  typedef enum logic [3:0] {
    K_NOP, K_LDI, K_PRINT, K_MOV, K_ADD, K_JZ, K_JMP, K_JNZ,
    K_LD, K_ST, K_PUSH, K_POP, K_HALT, K_BAD
  } op_kind_t;

  typedef enum logic [1:0] {
    ST_EXEC    = 2'd0,
    ST_HALT    = 2'd1,
    ST_BAD     = 2'd2,
    ST_IGNORED = 2'd3
  } status_t;

  // Register file write request
  typedef struct packed {
    logic       en;
    logic [3:0] idx;
    logic [7:0] data;
  } rf_wr_t;

  // Data memory write request
  typedef struct packed {
    logic        en;
    logic [15:0] addr;
    logic [7:0]  data;
  } dm_wr_t;

  // One result item
  typedef struct packed {
    status_t     status;
    logic [15:0] next_ip;
    logic        zero_flag;
    logic        carry_flag;
    logic        show_valid;
    logic [3:0]  show_reg;
    logic [7:0]  show_value;
  } result_t;

  function automatic op_kind_t decode(input logic [7:0] action);
    op_kind_t k;
    case (action)
      OP_NOP:   k = K_NOP;
      OP_LDI:   k = K_LDI;
      OP_PRINT: k = K_PRINT;
      OP_MOV:   k = K_MOV;
      OP_ADD:   k = K_ADD;
      OP_JZ:    k = K_JZ;
      OP_JMP:   k = K_JMP;
      OP_JNZ:   k = K_JNZ;
      OP_LD:    k = K_LD;
      OP_ST:    k = K_ST;
      OP_PUSH:  k = K_PUSH;
      OP_POP:   k = K_POP;
      OP_HALT:  k = K_HALT;
      default:  k = K_BAD;
    endcase
    return k;
  endfunction

  // Instruction length in bytes
  function automatic logic [2:0] op_length(input op_kind_t k);
    logic [2:0] n;
    case (k)
      K_PRINT, K_PUSH, K_POP:              n = 3'd2;
      K_LDI, K_MOV, K_ADD, K_JZ, K_JMP, K_JNZ: n = 3'd3;
      K_LD, K_ST:                          n = 3'd4;
      default:                             n = 3'd1;
    endcase
    return n;
  endfunction

endpackage

FILE: rtl/bcpu_regfile.sv
module bcpu_regfile #(
  parameter int REG_COUNT = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [3:0]       rd_idx_a,
  input  logic [3:0]       rd_idx_b,
  input  bcpu_pkg::rf_wr_t wr,
  output logic [7:0]       rd_data_a,
  output logic [7:0]       rd_data_b
);

  localparam int RF_DEPTH = (REG_COUNT < 16) ? REG_COUNT : 16;
  localparam int RF_AW    = $clog2(RF_DEPTH);

  logic [7:0]          mem [RF_DEPTH];
  logic [RF_DEPTH-1:0] written;
  logic                wr_ok, a_ok, b_ok;
  logic [7:0]          a_raw, b_raw, byp_data;
  logic                a_byp, b_byp, a_zero, b_zero;

  // Indexes at or above REG_COUNT read as zero and drop writes
  assign wr_ok = wr.en && (int'(wr.idx) < REG_COUNT);
  assign a_ok  = int'(rd_idx_a) < REG_COUNT;
  assign b_ok  = int'(rd_idx_b) < REG_COUNT;

  // Written marks stand in for the all-zero reset
  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
    end else if (wr_ok) begin
      written[wr.idx[RF_AW-1:0]] <= 1'b1;
    end
  end

  // One write port, two registered read ports, write-to-read bypass
  always_ff @(posedge clk) begin
    if (wr_ok) begin
      mem[wr.idx[RF_AW-1:0]] <= wr.data;
    end
    a_raw    <= mem[rd_idx_a[RF_AW-1:0]];
    b_raw    <= mem[rd_idx_b[RF_AW-1:0]];
    a_byp    <= wr_ok && (wr.idx == rd_idx_a);
    b_byp    <= wr_ok && (wr.idx == rd_idx_b);
    a_zero   <= !a_ok || !written[rd_idx_a[RF_AW-1:0]];
    b_zero   <= !b_ok || !written[rd_idx_b[RF_AW-1:0]];
    byp_data <= wr.data;
  end

  assign rd_data_a = a_byp ? byp_data : (a_zero ? 8'd0 : a_raw);
  assign rd_data_b = b_byp ? byp_data : (b_zero ? 8'd0 : b_raw);

endmodule

FILE: rtl/bcpu_dmem.sv
module bcpu_dmem #(
  parameter int ADDR_WIDTH = 16
) (
  input  logic                  clk,
  input  logic [ADDR_WIDTH-1:0] rd_addr,
  input  bcpu_pkg::dm_wr_t      wr,
  output logic [7:0]            rd_data
);

  localparam int DEPTH = 1 << ADDR_WIDTH;

  logic [7:0] mem [DEPTH];
  logic [7:0] raw, byp_data;
  logic       byp;

  // Byte memory, registered read, bypass when a write hits the read address
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr[ADDR_WIDTH-1:0]] <= wr.data;
    end
    raw      <= mem[rd_addr];
    byp      <= wr.en && (wr.addr[ADDR_WIDTH-1:0] == rd_addr);
    byp_data <= wr.data;
  end

  assign rd_data = byp ? byp_data : raw;

endmodule

FILE: rtl/bcpu_outq.sv
module bcpu_outq (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  bcpu_pkg::result_t push_data,
  input  logic              pop,
  output logic              head_valid,
  output bcpu_pkg::result_t head_data,
  output logic [1:0]        count
);

  bcpu_pkg::result_t q [bcpu_pkg::OQ_DEPTH];
  logic [1:0]        wr_ptr, rd_ptr;
  logic [1:0]        wr_ptr_next, rd_ptr_next;

  // Pointers wrap at the queue depth
  assign wr_ptr_next = (wr_ptr == 2'(bcpu_pkg::OQ_DEPTH - 1)) ? 2'd0 : wr_ptr + 2'd1;
  assign rd_ptr_next = (rd_ptr == 2'(bcpu_pkg::OQ_DEPTH - 1)) ? 2'd0 : rd_ptr + 2'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr_next;
      end
      if (pop) begin
        rd_ptr <= rd_ptr_next;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= push_data;
    end
  end

  assign head_valid = count != 2'd0;
  assign head_data  = q[rd_ptr];

endmodule

FILE: rtl/byte_cpu_execute_unit.sv
// Each item is registered into execute, then its result is queued. One
// item per cycle while the queue has room; the register file and data
// memory each take one read at accept and one write from the execute
// cycle, bypassed. A 3-entry result queue lets items enter while results
// wait downstream. Reset clears registers, flags, halted mark, pointers
// and the queue; the data memory is not cleared and needs no clearing pass.
module byte_cpu_execute_unit #(
  parameter int REG_COUNT  = 16,
  parameter int ADDR_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  // action[7:0], first_reg[11:8], second_reg[15:12],
  // target_address[31:16], immediate_value[39:32]
  input  logic [39:0] s_tdata,
  input  logic        s_tvalid,
  output logic        s_tready,
  // status[1:0], next_ip[17:2], zero_flag[18], carry_flag[19],
  // show_reg[23:20], show_value[31:24]
  output logic [31:0] m_tdata,
  // show_valid[0]
  output logic        m_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int AW = ADDR_WIDTH;

  logic [7:0]           in_action;
  logic [3:0]           in_first_reg, in_second_reg;
  logic [15:0]          in_target;
  logic [7:0]           in_imm;
  bcpu_pkg::op_kind_t   kind0;
  logic                 s_accept, m_pop, cfg_wr, cfg_wr_start, cfg_wr_stack;
  logic [15:0]          cfg_start, cfg_stack;
  logic                 halted;
  logic [AW-1:0]        sp, sp_dec, dm_rd_addr;

  logic                 s1_valid, s1_ignored;
  bcpu_pkg::op_kind_t   s1_kind;
  logic [3:0]           s1_ra, s1_rb;
  logic [AW-1:0]        s1_addr, s1_maddr;
  logic [7:0]           s1_imm;

  logic [AW-1:0]        ip, ip_next;
  logic                 zero, carry, zero_next, carry_next, jump;
  logic [7:0]           rd_a, rd_b, md;
  logic [8:0]           sum;
  bcpu_pkg::rf_wr_t     rf_wr;
  bcpu_pkg::dm_wr_t     dm_wr;
  bcpu_pkg::result_t    res, head;
  logic [1:0]           q_count;

  // Input unpack and decode
  assign in_action     = s_tdata[7:0];
  assign in_first_reg  = s_tdata[11:8];
  assign in_second_reg = s_tdata[15:12];
  assign in_target     = s_tdata[31:16];
  assign in_imm        = s_tdata[39:32];
  assign kind0         = bcpu_pkg::decode(in_action);

  // Room for the item in execute plus the new one
  assign s_tready = ({1'b0, q_count} + {2'b0, s1_valid}) < 3'(bcpu_pkg::OQ_DEPTH);
  assign s_accept = s_tvalid && s_tready;

  // Config port
  assign pready       = 1'b1;
  assign cfg_wr       = psel && penable && pwrite;
  assign cfg_wr_start = cfg_wr && (paddr[2] == bcpu_pkg::REG_START_ADDRESS);
  assign cfg_wr_stack = cfg_wr && (paddr[2] == bcpu_pkg::REG_INITIAL_STACK);

  always_comb begin
    case (paddr[2])
      bcpu_pkg::REG_START_ADDRESS: prdata = {16'd0, cfg_start};
      bcpu_pkg::REG_INITIAL_STACK: prdata = {16'd0, cfg_stack};
      default:                     prdata = '0;
    endcase
  end

  // Front: halted mark and stack pointer move at accept
  assign sp_dec     = sp - AW'(1);
  assign dm_rd_addr = (kind0 == bcpu_pkg::K_POP) ? sp : in_target[AW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_start <= '0;
      cfg_stack <= '0;
      sp        <= '0;
      halted    <= 1'b0;
    end else begin
      if (cfg_wr_start) begin
        cfg_start <= pwdata[15:0];
      end
      if (cfg_wr_stack) begin
        cfg_stack <= pwdata[15:0];
        sp        <= pwdata[AW-1:0];
      end
      if (s_accept && !halted) begin
        case (kind0)
          bcpu_pkg::K_PUSH: sp <= sp_dec;
          bcpu_pkg::K_POP:  sp <= sp + AW'(1);
          bcpu_pkg::K_HALT,
          bcpu_pkg::K_BAD:  halted <= 1'b1;
          default:          ;
        endcase
      end
    end
  end

  // Execute stage registers
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= s_accept;
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept) begin
      s1_kind    <= kind0;
      s1_ignored <= halted;
      s1_ra      <= in_first_reg;
      s1_rb      <= in_second_reg;
      s1_addr    <= in_target[AW-1:0];
      s1_imm     <= in_imm;
      s1_maddr   <= (kind0 == bcpu_pkg::K_PUSH) ? sp_dec : in_target[AW-1:0];
    end
  end

  bcpu_regfile #(.REG_COUNT(REG_COUNT)) u_regfile (
    .clk       (clk),
    .rst       (rst),
    .rd_idx_a  (in_first_reg),
    .rd_idx_b  (in_second_reg),
    .wr        (rf_wr),
    .rd_data_a (rd_a),
    .rd_data_b (rd_b)
  );

  bcpu_dmem #(.ADDR_WIDTH(AW)) u_dmem (
    .clk     (clk),
    .rd_addr (dm_rd_addr),
    .wr      (dm_wr),
    .rd_data (md)
  );

  // Execute: write-back, flags, next ip and result
  assign sum = {1'b0, rd_a} + {1'b0, rd_b};

  always_comb begin
    rf_wr          = '0;
    dm_wr          = '0;
    zero_next      = zero;
    carry_next     = carry;
    jump           = 1'b0;
    res            = '0;
    res.status     = bcpu_pkg::ST_EXEC;
    rf_wr.idx      = s1_ra;
    dm_wr.addr     = 16'(s1_maddr);
    dm_wr.data     = rd_a;
    if (s1_ignored) begin
      res.status = bcpu_pkg::ST_IGNORED;
    end else begin
      case (s1_kind)
        bcpu_pkg::K_LDI: begin
          rf_wr.en   = 1'b1;
          rf_wr.data = s1_imm;
        end
        bcpu_pkg::K_PRINT: begin
          res.show_valid = 1'b1;
          res.show_reg   = s1_ra;
          res.show_value = rd_a;
        end
        bcpu_pkg::K_MOV: begin
          rf_wr.en   = 1'b1;
          rf_wr.idx  = s1_rb;
          rf_wr.data = rd_a;
        end
        bcpu_pkg::K_ADD: begin
          rf_wr.en   = 1'b1;
          rf_wr.idx  = s1_rb;
          rf_wr.data = sum[7:0];
          carry_next = sum[8];
          zero_next  = sum[7:0] == 8'd0;
        end
        bcpu_pkg::K_JZ:  jump = zero;
        bcpu_pkg::K_JMP: jump = 1'b1;
        bcpu_pkg::K_JNZ: jump = !zero;
        bcpu_pkg::K_LD, bcpu_pkg::K_POP: begin
          rf_wr.en   = 1'b1;
          rf_wr.data = md;
        end
        bcpu_pkg::K_ST, bcpu_pkg::K_PUSH: dm_wr.en = 1'b1;
        bcpu_pkg::K_HALT: res.status = bcpu_pkg::ST_HALT;
        bcpu_pkg::K_BAD:  res.status = bcpu_pkg::ST_BAD;
        default: ;
      endcase
    end
    rf_wr.en = rf_wr.en && s1_valid;
    dm_wr.en = dm_wr.en && s1_valid;
    if (s1_ignored) begin
      ip_next = ip;
    end else if (jump) begin
      ip_next = s1_addr;
    end else begin
      ip_next = ip + AW'(bcpu_pkg::op_length(s1_kind));
    end
    res.next_ip    = 16'(ip_next);
    res.zero_flag  = zero_next;
    res.carry_flag = carry_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ip    <= '0;
      zero  <= 1'b0;
      carry <= 1'b0;
    end else begin
      if (cfg_wr_start) begin
        ip <= pwdata[AW-1:0];
      end
      if (s1_valid) begin
        ip    <= ip_next;
        zero  <= zero_next;
        carry <= carry_next;
      end
    end
  end

  // Result queue
  assign m_pop = m_tvalid && m_tready;

  bcpu_outq u_outq (
    .clk        (clk),
    .rst        (rst),
    .push       (s1_valid),
    .push_data  (res),
    .pop        (m_pop),
    .head_valid (m_tvalid),
    .head_data  (head),
    .count      (q_count)
  );

  assign m_tdata = {head.show_value, head.show_reg, head.carry_flag,
                    head.zero_flag, head.next_ip, head.status};
  assign m_tuser = head.show_valid;

  // Queue never overflows on a result push
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    s1_valid |-> (q_count != 2'd3 || m_pop))
    else $error("result queue overflow");

  // Halted mark holds until reset
  a_halt_sticky: assert property (@(posedge clk) disable iff (rst)
    halted |=> halted)
    else $error("halted mark cleared without reset");

  // Every accepted item reaches execute the next cycle
  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    s_accept |=> s1_valid)
    else $error("accepted item lost before execute");

  // Items taken while halted leave the stack pointer alone
  a_halt_sp: assert property (@(posedge clk) disable iff (rst)
    (s_accept && halted && !cfg_wr_stack) |=> $stable(sp))
    else $error("stack pointer moved while halted");

endmodule

FILE: tb/sv/bcpu_result_check.sv
`timescale 1ns / 1ps

// Watches both item channels and the APB port, predicts each result from the
// instruction stream and compares it against what the execute unit returns.
module bcpu_result_check (
  input  logic        clk,
  input  logic        rst,
  input  logic [39:0] s_tdata,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [31:0] m_tdata,
  input  logic        m_tuser,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          errors,
  output int          pending,
  output int          checked
);

  // Shadow machine state
  logic [7:0]  regs [16];
  logic [15:0] ip;
  logic [15:0] sp;
  logic        zf;
  logic        cf;
  logic        stopped;
  logic [7:0]  data_mem [logic [15:0]];

  bcpu_pkg::result_t expected_results [$];
  bcpu_pkg::result_t want;

  function automatic logic [7:0] stored_byte(input logic [15:0] addr);
    return data_mem.exists(addr) ? data_mem[addr] : 8'h00;
  endfunction

  // Run one instruction against the shadow state and return its result
  function automatic bcpu_pkg::result_t execute_instruction(input logic [39:0] word);
    logic [7:0]  op;
    logic [3:0]  ra;
    logic [3:0]  rb;
    logic [15:0] addr;
    logic [7:0]  imm;
    logic [7:0]  a_val;
    logic [7:0]  b_val;
    logic [8:0]  sum;
    logic [2:0]  len;
    logic        taken;
    bcpu_pkg::result_t r;
    op    = word[7:0];
    ra    = word[11:8];
    rb    = word[15:12];
    addr  = word[31:16];
    imm   = word[39:32];
    a_val = regs[ra];
    b_val = regs[rb];
    len   = 3'd1;
    taken = 1'b0;
    r     = '0;
    r.status = bcpu_pkg::ST_EXEC;
    if (stopped) begin
      r.status = bcpu_pkg::ST_IGNORED;
    end else begin
      case (op)
        bcpu_pkg::OP_NOP: ;
        bcpu_pkg::OP_LDI: begin
          regs[ra] = imm;
          len = 3'd3;
        end
        bcpu_pkg::OP_PRINT: begin
          r.show_valid = 1'b1;
          r.show_reg   = ra;
          r.show_value = a_val;
          len = 3'd2;
        end
        bcpu_pkg::OP_MOV: begin
          regs[rb] = a_val;
          len = 3'd3;
        end
        bcpu_pkg::OP_ADD: begin
          sum = {1'b0, a_val} + {1'b0, b_val};
          cf  = sum[8];
          zf  = (sum[7:0] == 8'h00);
          regs[rb] = sum[7:0];
          len = 3'd3;
        end
        bcpu_pkg::OP_JZ: begin
          taken = zf;
          len = 3'd3;
        end
        bcpu_pkg::OP_JMP: begin
          taken = 1'b1;
          len = 3'd3;
        end
        bcpu_pkg::OP_JNZ: begin
          taken = !zf;
          len = 3'd3;
        end
        bcpu_pkg::OP_LD: begin
          regs[ra] = stored_byte(addr);
          len = 3'd4;
        end
        bcpu_pkg::OP_ST: begin
          data_mem[addr] = a_val;
          len = 3'd4;
        end
        bcpu_pkg::OP_PUSH: begin
          sp = sp - 16'd1;
          data_mem[sp] = a_val;
          len = 3'd2;
        end
        bcpu_pkg::OP_POP: begin
          regs[ra] = stored_byte(sp);
          sp = sp + 16'd1;
          len = 3'd2;
        end
        bcpu_pkg::OP_HALT: begin
          stopped = 1'b1;
          r.status = bcpu_pkg::ST_HALT;
        end
        default: begin
          stopped = 1'b1;
          r.status = bcpu_pkg::ST_BAD;
        end
      endcase
      ip = taken ? addr : ip + 16'(len);
    end
    r.next_ip    = ip;
    r.zero_flag  = zf;
    r.carry_flag = cf;
    return r;
  endfunction

  function automatic void check_field(input string name, input int unsigned exp_val,
                                      input int unsigned act_val);
    if (exp_val != act_val) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp_val, act_val);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      foreach (regs[i]) regs[i] = 8'h00;
      ip      = 16'h0000;
      sp      = 16'h0000;
      zf      = 1'b0;
      cf      = 1'b0;
      stopped = 1'b0;
      data_mem.delete();
      expected_results.delete();
      errors  = 0;
      checked = 0;
    end else begin
      // Register writes load the pointers at once
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == bcpu_pkg::REG_START_ADDRESS)
          ip = pwdata[15:0];
        else
          sp = pwdata[15:0];
      end
      // Results leave before the new item is predicted
      if (m_tvalid && m_tready) begin
        if (expected_results.size() == 0) begin
          $error("result item 0x%0h with no instruction outstanding", m_tdata);
          errors++;
        end else begin
          want = expected_results.pop_front();
          check_field("status", want.status, m_tdata[1:0]);
          check_field("next_ip", want.next_ip, m_tdata[17:2]);
          check_field("zero_flag", want.zero_flag, m_tdata[18]);
          check_field("carry_flag", want.carry_flag, m_tdata[19]);
          check_field("show_valid", want.show_valid, m_tuser);
          check_field("show_reg", want.show_reg, m_tdata[23:20]);
          check_field("show_value", want.show_value, m_tdata[31:24]);
          checked++;
        end
      end
      if (s_tvalid && s_tready)
        expected_results.push_back(execute_instruction(s_tdata));
    end
    pending = expected_results.size();
  end

endmodule

FILE: tb/sv/tb_byte_cpu_execute_unit.sv
`timescale 1ns / 1ps

module tb_byte_cpu_execute_unit;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int PHASE_ITEMS  = 250;
  localparam int IGNORED_ITEMS = 40;
  localparam int DRAIN_CYCLES = 8;

  // Receiver stall patterns
  localparam int STALL_NONE    = 0;
  localparam int STALL_RANDOM  = 1;
  localparam int STALL_PATTERN = 2;
  localparam int STALL_LONG    = 3;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic [39:0] s_tdata = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] m_tdata;
  logic        m_tuser;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  int mismatches;
  int pending_results;
  int results_checked;
  int cycle_count = 0;
  int stall_mode = STALL_NONE;
  int stall_left = 0;
  int pattern_cnt = 0;
  int max_gap = 0;
  int burst_left = 0;
  int items_sent = 0;
  int settings_used = 1;
  bit halted_sent = 1'b0;

  // Stack pointer and written addresses, so loads and pops only hit known bytes
  logic [15:0] stack_ptr = 16'h0000;
  bit          mem_seen [logic [15:0]];
  logic [15:0] known_addrs [$];

  byte_cpu_execute_unit uut (
    .clk, .rst, .s_tdata, .s_tvalid, .s_tready, .m_tdata, .m_tuser, .m_tvalid,
    .m_tready, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  bcpu_result_check result_check (
    .clk, .rst, .s_tdata, .s_tvalid, .s_tready, .m_tdata, .m_tuser, .m_tvalid,
    .m_tready, .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .errors(mismatches), .pending(pending_results), .checked(results_checked)
  );

  always #4 clk = ~clk;

  // Run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $error("run did not finish within %0d cycles", CYCLE_LIMIT);
      $display("Some tests failed");
      $finish;
    end
  end

  // Result side backpressure
  always @(posedge clk) begin
    pattern_cnt <= pattern_cnt + 1;
    case (stall_mode)
      STALL_NONE:    m_tready <= 1'b1;
      STALL_RANDOM:  m_tready <= ($urandom_range(0, 3) != 0);
      STALL_PATTERN: m_tready <= ((pattern_cnt % 7) > 2);
      default: begin
        if (stall_left > 0) begin
          stall_left <= stall_left - 1;
          m_tready <= 1'b0;
        end else if ($urandom_range(0, 9) == 0) begin
          stall_left <= $urandom_range(1, 20);
          m_tready <= 1'b0;
        end else begin
          m_tready <= 1'b1;
        end
      end
    endcase
  end

  function automatic void note_written(input logic [15:0] addr);
    if (!mem_seen.exists(addr)) begin
      mem_seen[addr] = 1'b1;
      known_addrs.push_back(addr);
    end
  endfunction

  // Offer one instruction, in bursts separated by random gaps
  task automatic drive_item(input logic [7:0] op, input logic [3:0] ra,
                            input logic [3:0] rb, input logic [15:0] addr,
                            input logic [7:0] imm);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, max_gap);
      burst_left = $urandom_range(1, 16);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    s_tdata  <= {imm, addr, rb, ra, op};
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    burst_left--;
    items_sent++;
    if (!halted_sent) begin
      case (op)
        bcpu_pkg::OP_ST: note_written(addr);
        bcpu_pkg::OP_PUSH: begin
          stack_ptr = stack_ptr - 16'd1;
          note_written(stack_ptr);
        end
        bcpu_pkg::OP_POP: stack_ptr = stack_ptr + 16'd1;
        default: ;
      endcase
    end
  endtask

  // Hold off until every result is back and the pipe has drained
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic idx, input logic [15:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {16'h0000, value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    if (idx == bcpu_pkg::REG_INITIAL_STACK)
      stack_ptr = value;
  endtask

  function automatic logic [15:0] pick_address();
    case ($urandom_range(0, 3))
      0:       return 16'($urandom_range(0, 15));
      1:       return 16'($urandom_range(16'hFFF0, 16'hFFFF));
      default: return 16'($urandom);
    endcase
  endfunction

  // Random legal instruction; loads and pops only touch written bytes
  task automatic send_random();
    logic [7:0]  op;
    logic [3:0]  ra;
    logic [3:0]  rb;
    logic [15:0] addr;
    logic [7:0]  imm;
    int          pick;
    pick = $urandom_range(0, 99);
    ra   = 4'($urandom);
    rb   = 4'($urandom);
    addr = pick_address();
    case ($urandom_range(0, 5))
      0:       imm = 8'h00;
      1:       imm = 8'hFF;
      default: imm = 8'($urandom);
    endcase
    if (pick < 5)       op = bcpu_pkg::OP_NOP;
    else if (pick < 25) op = bcpu_pkg::OP_LDI;
    else if (pick < 35) op = bcpu_pkg::OP_PRINT;
    else if (pick < 43) op = bcpu_pkg::OP_MOV;
    else if (pick < 58) op = bcpu_pkg::OP_ADD;
    else if (pick < 62) op = bcpu_pkg::OP_JZ;
    else if (pick < 66) op = bcpu_pkg::OP_JMP;
    else if (pick < 70) op = bcpu_pkg::OP_JNZ;
    else if (pick < 78) op = bcpu_pkg::OP_LD;
    else if (pick < 86) op = bcpu_pkg::OP_ST;
    else if (pick < 93) op = bcpu_pkg::OP_PUSH;
    else                op = bcpu_pkg::OP_POP;
    if (op == bcpu_pkg::OP_LD) begin
      if (known_addrs.size() == 0)
        op = bcpu_pkg::OP_ST;
      else
        addr = known_addrs[$urandom_range(0, known_addrs.size() - 1)];
    end
    if (op == bcpu_pkg::OP_POP && !mem_seen.exists(stack_ptr))
      op = bcpu_pkg::OP_PUSH;
    drive_item(op, ra, rb, addr, imm);
  endtask

  initial begin
    logic [15:0] start_val;
    logic [15:0] stack_val;
    logic [7:0]  op;
    bit          end_by_halt;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed: flag corners, jumps both ways, pointer wrap, memory and stack
    stall_mode = STALL_RANDOM;
    max_gap = 3;
    drive_item(bcpu_pkg::OP_LDI,   4'd0,  4'd0,  16'h0000, 8'hFF);
    drive_item(bcpu_pkg::OP_LDI,   4'd15, 4'd0,  16'h0000, 8'h01);
    drive_item(bcpu_pkg::OP_ADD,   4'd0,  4'd15, 16'h0000, 8'h00);  // carry out, zero sum
    drive_item(bcpu_pkg::OP_JZ,    4'd0,  4'd0,  16'hFFFF, 8'h00);  // taken
    drive_item(bcpu_pkg::OP_NOP,   4'd0,  4'd0,  16'h0000, 8'h00);  // ip wraps to 0
    drive_item(bcpu_pkg::OP_JNZ,   4'd0,  4'd0,  16'h1234, 8'h00);  // not taken
    drive_item(bcpu_pkg::OP_LDI,   4'd3,  4'd0,  16'h0000, 8'h7F);
    drive_item(bcpu_pkg::OP_ADD,   4'd3,  4'd3,  16'h0000, 8'h00);  // same register twice
    drive_item(bcpu_pkg::OP_JNZ,   4'd0,  4'd0,  16'hABCD, 8'h00);  // taken
    drive_item(bcpu_pkg::OP_JZ,    4'd0,  4'd0,  16'h5555, 8'h00);  // not taken
    drive_item(bcpu_pkg::OP_JMP,   4'd0,  4'd0,  16'h0000, 8'h00);
    drive_item(bcpu_pkg::OP_PRINT, 4'd15, 4'd0,  16'h0000, 8'h00);
    drive_item(bcpu_pkg::OP_PRINT, 4'd3,  4'd0,  16'h0000, 8'h00);
    drive_item(bcpu_pkg::OP_MOV,   4'd0,  4'd7,  16'h0000, 8'h00);
    drive_item(bcpu_pkg::OP_PRINT, 4'd7,  4'd0,  16'h0000, 8'h00);
    drive_item(bcpu_pkg::OP_ST,    4'd3,  4'd0,  16'hFFFF, 8'h00);
    drive_item(bcpu_pkg::OP_LD,    4'd8,  4'd0,  16'hFFFF, 8'h00);  // read right after write
    drive_item(bcpu_pkg::OP_ST,    4'd0,  4'd0,  16'h0000, 8'h00);
    drive_item(bcpu_pkg::OP_LD,    4'd9,  4'd0,  16'h0000, 8'h00);
    drive_item(bcpu_pkg::OP_PUSH,  4'd3,  4'd0,  16'h0000, 8'h00);  // sp wraps below 0
    drive_item(bcpu_pkg::OP_PUSH,  4'd0,  4'd0,  16'h0000, 8'h00);
    drive_item(bcpu_pkg::OP_POP,   4'd10, 4'd0,  16'h0000, 8'h00);
    drive_item(bcpu_pkg::OP_POP,   4'd11, 4'd0,  16'h0000, 8'h00);  // sp wraps back to 0
    drive_item(bcpu_pkg::OP_ADD,   4'd1,  4'd2,  16'h0000, 8'h00);  // zero sum, no carry
    drive_item(bcpu_pkg::OP_PRINT, 4'd10, 4'd0,  16'h0000, 8'h00);

    // Random phases, each under its own pointer setting and flow pattern
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin
          start_val = 16'hFFF8;
          stack_val = 16'h0000;
        end
        1: begin
          start_val = 16'hFFFF;
          stack_val = 16'hFFFF;
        end
        2: begin
          start_val = 16'($urandom);
          stack_val = 16'($urandom);
        end
        default: begin
          start_val = 16'h0000;
          stack_val = 16'h8000;
        end
      endcase
      wait_idle();
      cfg_write(bcpu_pkg::REG_START_ADDRESS, start_val);
      cfg_write(bcpu_pkg::REG_INITIAL_STACK, stack_val);
      settings_used++;
      stall_mode = p;
      max_gap = (p == 0) ? 0 : 2 * p + 2;
      repeat (PHASE_ITEMS) send_random();
    end

    // Stop the machine once, then check that later items are ignored
    wait_idle();
    stall_mode = STALL_RANDOM;
    max_gap = 4;
    end_by_halt = ($urandom_range(0, 1) == 1);
    if (end_by_halt)
      op = bcpu_pkg::OP_HALT;
    else
      do op = 8'($urandom);
      while (op inside {bcpu_pkg::OP_NOP, bcpu_pkg::OP_LDI, bcpu_pkg::OP_PRINT,
                        bcpu_pkg::OP_MOV, bcpu_pkg::OP_ADD, bcpu_pkg::OP_JZ,
                        bcpu_pkg::OP_JMP, bcpu_pkg::OP_JNZ, bcpu_pkg::OP_LD,
                        bcpu_pkg::OP_ST, bcpu_pkg::OP_PUSH, bcpu_pkg::OP_POP,
                        bcpu_pkg::OP_HALT});
    drive_item(op, 4'($urandom), 4'($urandom), 16'($urandom), 8'($urandom));
    halted_sent = 1'b1;
    repeat (IGNORED_ITEMS) begin
      op = 8'($urandom);
      if (op == bcpu_pkg::OP_LD && known_addrs.size() > 0)
        drive_item(op, 4'($urandom), 4'($urandom),
                   known_addrs[$urandom_range(0, known_addrs.size() - 1)], 8'($urandom));
      else if ((op == bcpu_pkg::OP_LD) ||
               (op == bcpu_pkg::OP_POP && !mem_seen.exists(stack_ptr)))
        drive_item(bcpu_pkg::OP_PUSH, 4'($urandom), 4'($urandom), 16'($urandom),
                   8'($urandom));
      else
        drive_item(op, 4'($urandom), 4'($urandom), 16'($urandom), 8'($urandom));
    end

    wait_idle();
    $display("Sent %0d instructions under %0d pointer settings, %0d results compared",
             items_sent, settings_used, results_checked);
    $display("Machine stopped by %s, then fed %0d ignored items",
             end_by_halt ? "halt" : "an undefined opcode", IGNORED_ITEMS);
    if (mismatches == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
